// ===== src/ffca_pkg.sv =====
// Shared constants and types of the first-fit chunk allocator.
package ffca_pkg;

	// Pool geometry.
	localparam int NUM_CHUNKS  = 4096;
	localparam int CHUNK_BYTES = 8;
	localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
	localparam int IDX_W       = $clog2(NUM_CHUNKS);

	// Field widths.
	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 16;
	localparam int COUNT_W = 16;
	localparam int MAP_W   = 13;

	// Scan position before the range check: a chunk index plus a map entry.
	localparam int NXT_W = $clog2(NUM_CHUNKS + (1 << MAP_W));

	// Reset values.
	localparam logic [ADDR_W-1:0]  POOL_BASE_RESET = 32'h0060_0000;
	localparam logic [COUNT_W-1:0] POOL_BYTES      = COUNT_W'(NUM_CHUNKS * CHUNK_BYTES);

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef logic [IDX_W-1:0] chunk_idx_t;
	typedef logic [MAP_W-1:0] map_entry_t;

endpackage

// ===== src/ffca_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ffca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read in the same clock.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/first_fit_chunk_allocator_core.sv =====
// Top level of the first-fit chunk allocator: request decode, map scan and result register.
//
// Use of the block:
// The input channel carries one request per beat: req_type selects allocate or
// free, alloc_bytes gives the size of an allocate and free_address the byte
// address of a free. The output channel returns one result per request with the
// granted address, ok, and the vacant and occupied byte counts after it.
// pool_base is written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. After reset the
// chunk map is cleared by a pass over all 4096 entries, one entry per cycle, during
// which in_stall stays high; the counts and pool_base reset at once. A request that
// fails its size or address checks goes straight to the done state. A free reads the
// map entry of its chunk and, if the entry is nonzero, clears it. An allocate walks the
// map from chunk 0 at one map entry per cycle, jumping over a live allocation in one
// step, until it finds a free run of the needed length or passes the end of the map.
// One request is worked on at a time. A result waits in the output register while
// out_stall is high, and the next request may be accepted and worked on meanwhile;
// its result is held back until the output register is free.
module first_fit_chunk_allocator_core
	import ffca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Configuration.
	input  logic                cfg_wr_en,
	input  logic [ADDR_W-1:0]   cfg_wr_data,
	// Request channel.
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [SIZE_W-1:0]   alloc_bytes,
	input  logic [ADDR_W-1:0]   free_address,
	// Result channel.
	output logic                out_valid,
	input  logic                out_stall,
	output logic [ADDR_W-1:0]   granted_address,
	output logic                ok,
	output logic [COUNT_W-1:0]  vacant_bytes,
	output logic [COUNT_W-1:0]  occupied_bytes
);

	// Controller states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FREE  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]          state_q;
	chunk_idx_t          clr_idx_q;
	logic [ADDR_W-1:0]   pool_base_q;
	logic [COUNT_W-1:0]  vacant_q;
	logic [COUNT_W-1:0]  occupied_q;

	// Working registers of the current request.
	chunk_idx_t          cur_q;
	chunk_idx_t          pos_q;
	map_entry_t          len_q;
	map_entry_t          need_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                res_ok_q;

	// Output register.
	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic                out_ok_q;
	logic [COUNT_W-1:0]  out_vacant_q;
	logic [COUNT_W-1:0]  out_occupied_q;

	// Map port signals.
	logic                ram_wr_en;
	chunk_idx_t          ram_wr_addr;
	map_entry_t          ram_wr_data;
	chunk_idx_t          ram_rd_addr;
	map_entry_t          ram_rd_data;

	// Decode of the request at the input.
	logic                in_accept;
	logic [SIZE_W:0]     rounded;
	logic                alloc_good;
	logic [ADDR_W-1:0]   free_off;
	logic                free_good;
	chunk_idx_t          free_idx;

	// Scan step.
	logic                entry_nz;
	logic [NXT_W-1:0]    jump_pos;
	logic [NXT_W-1:0]    step_pos;
	map_entry_t          len_inc;
	logic                run_found;
	logic                jump_out;
	logic                step_out;
	logic                out_free;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Round up to whole chunks; check nonzero, no overflow and not above the vacant bytes.
	assign rounded    = ({1'b0, alloc_bytes} + (SIZE_W + 1)'(CHUNK_BYTES - 1))
		& ~(SIZE_W + 1)'(CHUNK_BYTES - 1);
	assign alloc_good = (rounded != '0) && !rounded[SIZE_W]
		&& (rounded <= {1'b0, vacant_q});

	// A free must be nonzero and land on a chunk boundary inside the pool.
	assign free_off  = free_address - pool_base_q;
	assign free_good = (free_address != '0) && (free_address >= pool_base_q)
		&& (free_off[CHUNK_SHIFT-1:0] == '0)
		&& (free_off[ADDR_W-1:IDX_W+CHUNK_SHIFT] == '0);
	assign free_idx  = free_off[IDX_W+CHUNK_SHIFT-1:CHUNK_SHIFT];

	// One map entry per cycle: jump over a live allocation or extend the free run.
	assign entry_nz  = (ram_rd_data != '0);
	assign jump_pos  = NXT_W'(cur_q) + NXT_W'(ram_rd_data);
	assign step_pos  = NXT_W'(cur_q) + NXT_W'(1);
	assign len_inc   = len_q + MAP_W'(1);
	assign run_found = !entry_nz && (len_inc == need_q);
	assign jump_out  = (jump_pos >= NXT_W'(NUM_CHUNKS));
	assign step_out  = (step_pos >= NXT_W'(NUM_CHUNKS));

	// Map read address and write port.
	always_comb begin
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = clr_idx_q;
		ram_wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr_en = 1'b1;
			end
			ST_IDLE: begin
				ram_rd_addr = (req_type == REQ_FREE) ? free_idx : '0;
			end
			ST_SCAN: begin
				ram_rd_addr = entry_nz ? jump_pos[IDX_W-1:0] : step_pos[IDX_W-1:0];
				if (run_found) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = pos_q;
					ram_wr_data = need_q;
				end
			end
			ST_FREE: begin
				ram_wr_en   = entry_nz;
				ram_wr_addr = cur_q;
			end
			ST_DONE: begin
				ram_rd_addr = '0;
			end
			default: begin
				ram_rd_addr = '0;
			end
		endcase
	end

	ffca_ram #(
		.WIDTH (MAP_W),
		.DEPTH (NUM_CHUNKS)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Control state, counts and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			pool_base_q <= POOL_BASE_RESET;
			vacant_q    <= POOL_BYTES;
			occupied_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pool_base_q <= cfg_wr_data;
			end
			// The output register fills from the done state and empties on a taken beat.
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(NUM_CHUNKS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						if (req_type == REQ_ALLOC) begin
							state_q <= alloc_good ? ST_SCAN : ST_DONE;
						end else begin
							state_q <= free_good ? ST_FREE : ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (run_found) begin
						vacant_q   <= vacant_q - size_q;
						occupied_q <= occupied_q + size_q;
						state_q    <= ST_DONE;
					end else if (entry_nz ? jump_out : step_out) begin
						state_q <= ST_DONE;
					end
				end
				ST_FREE: begin
					if (entry_nz) begin
						vacant_q   <= vacant_q + {ram_rd_data, CHUNK_SHIFT'(0)};
						occupied_q <= occupied_q - {ram_rd_data, CHUNK_SHIFT'(0)};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					cur_q      <= (req_type == REQ_FREE) ? free_idx : '0;
					pos_q      <= '0;
					len_q      <= '0;
					need_q     <= rounded[SIZE_W-1:CHUNK_SHIFT];
					size_q     <= rounded[SIZE_W-1:0];
					res_addr_q <= '0;
					res_ok_q   <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (run_found) begin
					res_addr_q <= pool_base_q + ADDR_W'({pos_q, CHUNK_SHIFT'(0)});
					res_ok_q   <= 1'b1;
				end else if (entry_nz) begin
					cur_q <= jump_pos[IDX_W-1:0];
					pos_q <= jump_pos[IDX_W-1:0];
					len_q <= '0;
				end else begin
					cur_q <= step_pos[IDX_W-1:0];
					len_q <= len_inc;
				end
			end
			ST_FREE: begin
				res_ok_q <= entry_nz;
			end
			ST_DONE: begin
				if (out_free) begin
					out_addr_q     <= res_addr_q;
					out_ok_q       <= res_ok_q;
					out_vacant_q   <= vacant_q;
					out_occupied_q <= occupied_q;
				end
			end
			default: begin
				res_ok_q <= res_ok_q;
			end
		endcase
	end

	// Output beat.
	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign ok              = out_ok_q;
	assign vacant_bytes    = out_vacant_q;
	assign occupied_bytes  = out_occupied_q;

endmodule
